>>> rtl/bscpc_pkg.sv
// Package for the boiler sensor check and pump control block.
// Holds the queue entry and limit types, reset values and the fraction digit table.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bscpc_pkg;

  localparam int unsigned SensorCountDefault = 9;
  localparam int unsigned RegCount           = 6;
  localparam int unsigned AddrWidth          = 5;
  localparam int unsigned LimitWidth         = 7;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegColdLimit      = 3'd0;
  localparam logic [2:0] RegFireStartLimit = 3'd1;
  localparam logic [2:0] RegPumpOMin       = 3'd2;
  localparam logic [2:0] RegPumpBLimit     = 3'd3;
  localparam logic [2:0] RegFireHotLimit   = 3'd4;
  localparam logic [2:0] RegOverheatLimit  = 3'd5;

  // Reset values of the limits.
  localparam logic [6:0] ColdLimitReset      = 7'd25;
  localparam logic [6:0] FireStartLimitReset = 7'd32;
  localparam logic [6:0] PumpOMinReset       = 7'd42;
  localparam logic [6:0] PumpBLimitReset     = 7'd46;
  localparam logic [6:0] FireHotLimitReset   = 7'd50;
  localparam logic [6:0] OverheatLimitReset  = 7'd96;

  localparam logic [6:0] CharZero = 7'h30;
  localparam logic [6:0] CharNine = 7'h39;
  localparam logic [6:0] CharDash = 7'h2D;

  // Reading handed from the front end to the back end.
  typedef struct packed {
    logic [3:0]  sensor;
    logic        ok;
    logic        neg;
    logic [15:0] temp;
    logic        dv;
    logic [7:0]  boiler;
    logic [7:0]  outlet;
    logic [7:0]  house;
    logic [7:0]  flue;
  } bscpc_entry_t;

  typedef struct packed {
    logic [6:0] cold_limit;
    logic [6:0] fire_start_limit;
    logic [6:0] pump_o_min;
    logic [6:0] pump_b_limit;
    logic [6:0] fire_hot_limit;
    logic [6:0] overheat_limit;
  } bscpc_cfg_t;

  // Two decimal digits of a sixteenth, high digit in the upper nibble.
  function automatic logic [7:0] frac_digits(input logic [3:0] sixteenths);
    logic [7:0] d;
    case (sixteenths)
      4'd0:    d = 8'h00;
      4'd1:    d = 8'h06;
      4'd2:    d = 8'h12;
      4'd3:    d = 8'h19;
      4'd4:    d = 8'h25;
      4'd5:    d = 8'h31;
      4'd6:    d = 8'h38;
      4'd7:    d = 8'h44;
      4'd8:    d = 8'h50;
      4'd9:    d = 8'h56;
      4'd10:   d = 8'h62;
      4'd11:   d = 8'h69;
      4'd12:   d = 8'h75;
      4'd13:   d = 8'h81;
      4'd14:   d = 8'h88;
      4'd15:   d = 8'h94;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bscpc_front.sv
// Front end of the boiler sensor check: takes scratchpad bytes, runs the CRC-8,
// captures the raw reading and the kept temperatures, and queues a reading on byte 8.
// Depends on bscpc_pkg.
`default_nettype none

module bscpc_front
  import bscpc_pkg::*;
#(
  parameter int unsigned SensorCount = SensorCountDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_stall_i,
  input  wire logic [3:0]   sensor_number_i,
  input  wire logic [3:0]   byte_number_i,
  input  wire logic [7:0]   scratch_byte_i,
  output logic              push_o,
  output bscpc_entry_t      entry_o
);

  localparam logic [4:0] SensorLimit = 5'(SensorCount);
  localparam logic [3:0] LastSensor  = 4'(SensorCount - 1);

  function automatic logic [7:0] crc_update(input logic [7:0] crc_in,
                                            input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] b;
    logic       mix;
    crc = crc_in;
    b   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ b[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ 8'h8C;
      end
      b = b >> 1;
    end
    return crc;
  endfunction

  logic [7:0]  crc_q, crc_d;
  logic [7:0]  raw_low_q, raw_high_q;
  logic [15:0] kept_q [4];
  logic [15:0] kept_d [4];

  logic        take;
  logic        is_crc_byte;
  logic        ok;
  logic [15:0] raw;
  logic [15:0] mag;
  logic [1:0]  slot;
  logic        has_slot;

  assign take = in_valid_i && !in_stall_i && ({1'b0, sensor_number_i} < SensorLimit)
                && (byte_number_i <= 4'd8);
  assign is_crc_byte = (byte_number_i == 4'd8);

  assign crc_d = crc_update((byte_number_i == 4'd0) ? 8'h00 : crc_q, scratch_byte_i);

  assign ok  = (crc_q == scratch_byte_i);
  assign raw = {raw_high_q, raw_low_q};
  assign mag = raw[15] ? (16'h0000 - raw) : raw;

  always_comb begin
    has_slot = 1'b1;
    case (sensor_number_i)
      4'd0:    slot = 2'd0;
      4'd5:    slot = 2'd1;
      4'd6:    slot = 2'd2;
      4'd8:    slot = 2'd3;
      default: begin
        slot     = 2'd0;
        has_slot = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      kept_d[i] = kept_q[i];
    end
    if (take && is_crc_byte && ok && has_slot) begin
      kept_d[slot] = mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= 8'h00;
      raw_low_q  <= 8'h00;
      raw_high_q <= 8'h00;
      for (int i = 0; i < 4; i++) begin
        kept_q[i] <= 16'h0000;
      end
    end else if (take) begin
      if (!is_crc_byte) begin
        crc_q <= crc_d;
        if (byte_number_i == 4'd0) begin
          raw_low_q <= scratch_byte_i;
        end
        if (byte_number_i == 4'd1) begin
          raw_high_q <= scratch_byte_i;
        end
      end
      for (int i = 0; i < 4; i++) begin
        kept_q[i] <= kept_d[i];
      end
    end
  end

  assign push_o         = take && is_crc_byte;
  assign entry_o.sensor = sensor_number_i;
  assign entry_o.ok     = ok;
  assign entry_o.neg    = raw[15];
  assign entry_o.temp   = mag;
  assign entry_o.dv     = (sensor_number_i == LastSensor);
  assign entry_o.boiler = kept_d[0][11:4];
  assign entry_o.outlet = kept_d[1][11:4];
  assign entry_o.house  = kept_d[2][11:4];
  assign entry_o.flue   = kept_d[3][11:4];

endmodule

`default_nettype wire

>>> rtl/bscpc_queue.sv
// Two-entry queue of readings between the front end and the back end.
// Depends on bscpc_pkg for the entry type.
`default_nettype none

module bscpc_queue
  import bscpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  bscpc_entry_t      push_entry_i,
  input  wire logic         pop_i,
  output logic              full_o,
  output logic              empty_o,
  output bscpc_entry_t      head_o
);

  bscpc_entry_t slot_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/bscpc_back.sv
// Back end of the boiler sensor check: turns a queued reading into ASCII
// characters and pump decisions and holds the result in the output register.
// Depends on bscpc_pkg.
`default_nettype none

module bscpc_back
  import bscpc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  bscpc_entry_t      head_i,
  output logic              pop_o,
  input  bscpc_cfg_t        cfg_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [3:0]        reading_sensor_o,
  output logic              reading_ok_o,
  output logic [6:0]        tens_char_o,
  output logic [6:0]        units_char_o,
  output logic [6:0]        frac_high_char_o,
  output logic [6:0]        frac_low_char_o,
  output logic              decision_valid_o,
  output logic              overheat_alarm_o,
  output logic              fire_on_o,
  output logic              pump_o_on_o,
  output logic              pump_b_on_o,
  output logic [5:0]        status_char_o
);

  logic        out_valid_q;
  logic [3:0]  sensor_q;
  logic        ok_q;
  logic [6:0]  tens_q, units_q, frac_hi_q, frac_lo_q;
  logic        dv_q, al_q, fi_q, po_q, pb_q;

  logic [10:0] whole;
  logic [22:0] prod;
  logic [7:0]  quot;
  logic [10:0] quot_x10;
  logic [3:0]  rem;
  logic [7:0]  tens_raw;
  logic [7:0]  digits;
  logic [6:0]  tens_c, units_c, frac_hi_c, frac_lo_c;
  logic        al_c, fi_c, po_c, pb_c;
  logic [7:0]  cold, start, omin, blim, hot, ovh;

  // Divide by ten as a multiply by 3277/32768, exact for every 11-bit value.
  assign whole    = head_i.temp[14:4];
  assign prod     = 23'(whole) * 23'd3277;
  assign quot     = prod[22:15];
  assign quot_x10 = 11'({quot, 3'b000}) + 11'({quot, 1'b0});
  assign rem      = 4'(whole - quot_x10);
  assign digits   = frac_digits(head_i.temp[3:0]);

  always_comb begin
    tens_raw = quot | {1'b0, CharZero};
    if (!tens_raw[7] && (tens_raw > {1'b0, CharNine})) begin
      tens_raw = tens_raw - 8'd10;
    end
    if (!head_i.ok) begin
      tens_c    = CharDash;
      units_c   = CharDash;
      frac_hi_c = CharDash;
      frac_lo_c = CharDash;
    end else begin
      frac_hi_c = CharZero | {3'b000, digits[7:4]};
      frac_lo_c = CharZero | {3'b000, digits[3:0]};
      if (head_i.neg) begin
        tens_c  = CharDash;
        units_c = CharZero | {3'b000, head_i.temp[7:4]};
      end else begin
        tens_c  = tens_raw[6:0];
        units_c = CharZero | {3'b000, rem};
      end
    end
  end

  assign cold  = {1'b0, cfg_i.cold_limit};
  assign start = {1'b0, cfg_i.fire_start_limit};
  assign omin  = {1'b0, cfg_i.pump_o_min};
  assign blim  = {1'b0, cfg_i.pump_b_limit};
  assign hot   = {1'b0, cfg_i.fire_hot_limit};
  assign ovh   = {1'b0, cfg_i.overheat_limit};

  always_comb begin
    al_c = 1'b0;
    fi_c = 1'b0;
    po_c = 1'b0;
    pb_c = 1'b0;
    if (head_i.dv) begin
      al_c = (head_i.boiler >= ovh);
      if (!al_c) begin
        fi_c = (head_i.flue >= hot) || ((head_i.flue >= start) && (head_i.boiler < hot));
        po_c = (head_i.house < head_i.boiler) && (head_i.house < cold)
               && (!fi_c || (head_i.outlet >= omin));
        pb_c = fi_c && (head_i.outlet < hot) && (!po_c || (head_i.outlet < blim))
               && ((head_i.house < cold) || (head_i.outlet < cold));
      end
    end
  end

  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sensor_q  <= head_i.sensor;
      ok_q      <= head_i.ok;
      tens_q    <= tens_c;
      units_q   <= units_c;
      frac_hi_q <= frac_hi_c;
      frac_lo_q <= frac_lo_c;
      dv_q      <= head_i.dv;
      al_q      <= al_c;
      fi_q      <= fi_c;
      po_q      <= po_c;
      pb_q      <= pb_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reading_sensor_o = sensor_q;
  assign reading_ok_o     = ok_q;
  assign tens_char_o      = tens_q;
  assign units_char_o     = units_q;
  assign frac_high_char_o = frac_hi_q;
  assign frac_low_char_o  = frac_lo_q;
  assign decision_valid_o = dv_q;
  assign overheat_alarm_o = al_q;
  assign fire_on_o        = fi_q;
  assign pump_o_on_o      = po_q;
  assign pump_b_on_o      = pb_q;
  assign status_char_o    = {2'b11, al_q, fi_q, po_q, pb_q};

endmodule

`default_nettype wire

>>> rtl/boiler_sensor_check_and_pump_control.sv
// Top level of the boiler sensor check and pump control block.
// Holds the limit registers behind the APB-style port and joins front end, queue and back end.
// Depends on bscpc_pkg, bscpc_front, bscpc_queue and bscpc_back.
`default_nettype none

// The block takes one scratchpad byte per request and accepts a new request in
// every clock cycle, so long as the two-entry reading queue is not full; only a
// result that the downstream side holds stalled can fill that queue and stall
// the input. Bytes 0 to 7 of a sensor only update the CRC-8 and the raw reading,
// and give no result. Byte 8 gives one result, which passes through the reading
// queue into the output register: the front end checks the CRC and updates the
// kept temperatures in the accepting cycle, and the back end forms the ASCII
// characters and the alarm, fire and pump flags as it loads the output
// register. The flags are valid only on the last sensor's byte 8. The six
// limits sit at byte addresses 0, 4, 8, 12, 16 and 20, are seven bits wide, and
// may be written only while no reading is in flight; reads return their values.

module boiler_sensor_check_and_pump_control
  import bscpc_pkg::*;
#(
  parameter int unsigned SensorCount = SensorCountDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [3:0]           sensor_number_i,
  input  wire logic [3:0]           byte_number_i,
  input  wire logic [7:0]           scratch_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [3:0]                reading_sensor_o,
  output logic                      reading_ok_o,
  output logic [6:0]                tens_char_o,
  output logic [6:0]                units_char_o,
  output logic [6:0]                frac_high_char_o,
  output logic [6:0]                frac_low_char_o,
  output logic                      decision_valid_o,
  output logic                      overheat_alarm_o,
  output logic                      fire_on_o,
  output logic                      pump_o_on_o,
  output logic                      pump_b_on_o,
  output logic [5:0]                status_char_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  bscpc_cfg_t   cfg_q;
  bscpc_entry_t push_entry;
  bscpc_entry_t head;
  logic         push, pop, full, empty;
  logic         cfg_write;
  logic [2:0]   reg_index;
  logic [6:0]   read_value;

  // Configuration registers. The port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cold_limit       <= ColdLimitReset;
      cfg_q.fire_start_limit <= FireStartLimitReset;
      cfg_q.pump_o_min       <= PumpOMinReset;
      cfg_q.pump_b_limit     <= PumpBLimitReset;
      cfg_q.fire_hot_limit   <= FireHotLimitReset;
      cfg_q.overheat_limit   <= OverheatLimitReset;
    end else if (cfg_write) begin
      case (reg_index)
        RegColdLimit:      cfg_q.cold_limit       <= pwdata[6:0];
        RegFireStartLimit: cfg_q.fire_start_limit <= pwdata[6:0];
        RegPumpOMin:       cfg_q.pump_o_min       <= pwdata[6:0];
        RegPumpBLimit:     cfg_q.pump_b_limit     <= pwdata[6:0];
        RegFireHotLimit:   cfg_q.fire_hot_limit   <= pwdata[6:0];
        RegOverheatLimit:  cfg_q.overheat_limit   <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  // Addresses beyond the last limit read as zero.
  always_comb begin
    case (reg_index)
      RegColdLimit:      read_value = cfg_q.cold_limit;
      RegFireStartLimit: read_value = cfg_q.fire_start_limit;
      RegPumpOMin:       read_value = cfg_q.pump_o_min;
      RegPumpBLimit:     read_value = cfg_q.pump_b_limit;
      RegFireHotLimit:   read_value = cfg_q.fire_hot_limit;
      RegOverheatLimit:  read_value = cfg_q.overheat_limit;
      default:           read_value = 7'd0;
    endcase
  end

  assign prdata = {25'd0, read_value};

  // The input stalls only while the reading queue is full.
  assign in_stall_o = full;

  bscpc_front #(
    .SensorCount(SensorCount)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (full),
    .sensor_number_i(sensor_number_i),
    .byte_number_i  (byte_number_i),
    .scratch_byte_i (scratch_byte_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  bscpc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  bscpc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .cfg_i           (cfg_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reading_sensor_o(reading_sensor_o),
    .reading_ok_o    (reading_ok_o),
    .tens_char_o     (tens_char_o),
    .units_char_o    (units_char_o),
    .frac_high_char_o(frac_high_char_o),
    .frac_low_char_o (frac_low_char_o),
    .decision_valid_o(decision_valid_o),
    .overheat_alarm_o(overheat_alarm_o),
    .fire_on_o       (fire_on_o),
    .pump_o_on_o     (pump_o_on_o),
    .pump_b_on_o     (pump_b_on_o),
    .status_char_o   (status_char_o)
  );

endmodule

`default_nettype wire
